FILE: hdl/hnf_pkg.sv
// Package for the HDLC NRZI transmit framer.
// Holds command codes, constants and the controller/datapath interface structs.
`default_nettype none

package hnf_pkg;

	localparam logic [1:0] MODE_DATA  = 2'd0;
	localparam logic [1:0] MODE_FLAG  = 2'd1;
	localparam logic [1:0] MODE_FCS   = 2'd2;
	localparam logic [1:0] MODE_RESET = 2'd3;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h8408;
	localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
	localparam logic [2:0]  ONES_MAX   = 3'd7;
	localparam logic [2:0]  ONES_STUFF = 3'd4;
	localparam logic [4:0]  BYTE_BITS  = 5'd8;
	localparam logic [4:0]  FCS_BITS   = 5'd16;

	typedef struct packed {
		logic load;
		logic crc_init;
		logic emit_bit;
		logic emit_stuff;
	} hnf_cmd_t;

	typedef struct packed {
		logic out_free;
		logic stuff_now;
		logic final_bit;
		logic cnt_zero;
	} hnf_sts_t;

endpackage

`default_nettype wire

FILE: hdl/hnf_ctrl.sv
// Controller state machine for the HDLC NRZI transmit framer.
// Depends on hnf_pkg; drives commands to hnf_dpath from its status.
`default_nettype none

module hnf_ctrl
	import hnf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire hnf_sts_t   sts,
	output hnf_cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SEND  = 3'b010,
		ST_STUFF = 3'b100
	} hnf_state_t;

	hnf_state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (mode == MODE_RESET) begin
						cmd.crc_init = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_SEND;
					end
				end
			end
			ST_SEND: begin
				if (sts.out_free) begin
					cmd.emit_bit = 1'b1;
					if (sts.stuff_now) begin
						state_d = ST_STUFF;
					end else if (sts.final_bit) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_STUFF: begin
				if (sts.out_free) begin
					cmd.emit_stuff = 1'b1;
					state_d = sts.cnt_zero ? ST_IDLE : ST_SEND;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/hnf_dpath.sv
// Datapath for the HDLC NRZI transmit framer: shifter, CRC, stuffing, NRZI, output register.
// Depends on hnf_pkg; steered by hnf_ctrl.
`default_nettype none

module hnf_dpath
	import hnf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] data_byte,
	input  wire hnf_cmd_t   cmd,
	output hnf_sts_t        sts,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            line_level,
	output logic            stuffed_bit,
	output logic            last_bit
);

	logic [15:0] crc_q;
	logic [15:0] sh_q;
	logic [4:0]  cnt_q;
	logic [2:0]  ones_q;
	logic        level_q;
	logic        stuff_en_q;
	logic        crc_en_q;
	logic        out_valid_q;
	logic        line_q;
	logic        stuffed_q;
	logic        last_q;
	logic        cur_bit;
	logic [15:0] crc_next;

	assign cur_bit = sh_q[0];

	always_comb begin
		crc_next = {1'b0, crc_q[15:1]};
		if (crc_q[0] ^ cur_bit) begin
			crc_next = crc_next ^ CRC_POLY;
		end
	end

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.stuff_now = stuff_en_q && cur_bit && (ones_q == ONES_STUFF);
	assign sts.final_bit = (cnt_q == 5'd1);
	assign sts.cnt_zero  = (cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_PRESET;
			sh_q        <= '0;
			cnt_q       <= '0;
			ones_q      <= '0;
			level_q     <= 1'b0;
			stuff_en_q  <= 1'b0;
			crc_en_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.crc_init) begin
				crc_q <= CRC_PRESET;
			end
			if (cmd.load) begin
				case (mode)
					MODE_DATA: begin
						sh_q       <= {8'h00, data_byte};
						cnt_q      <= BYTE_BITS;
						stuff_en_q <= 1'b1;
						crc_en_q   <= 1'b1;
					end
					MODE_FLAG: begin
						sh_q       <= {8'h00, FLAG_BYTE};
						cnt_q      <= BYTE_BITS;
						stuff_en_q <= 1'b0;
						crc_en_q   <= 1'b0;
					end
					default: begin
						sh_q       <= ~crc_q;
						cnt_q      <= FCS_BITS;
						stuff_en_q <= 1'b1;
						crc_en_q   <= 1'b0;
					end
				endcase
			end
			if (cmd.emit_bit) begin
				sh_q        <= {1'b0, sh_q[15:1]};
				cnt_q       <= cnt_q - 5'd1;
				out_valid_q <= 1'b1;
				if (crc_en_q) begin
					crc_q <= crc_next;
				end
				if (cur_bit) begin
					if (sts.stuff_now) begin
						ones_q <= '0;
					end else if (ones_q != ONES_MAX) begin
						ones_q <= ones_q + 3'd1;
					end
				end else begin
					ones_q  <= '0;
					level_q <= ~level_q;
				end
			end
			if (cmd.emit_stuff) begin
				level_q     <= ~level_q;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bit) begin
			line_q    <= cur_bit ? level_q : ~level_q;
			stuffed_q <= 1'b0;
			last_q    <= sts.final_bit && !sts.stuff_now;
		end else if (cmd.emit_stuff) begin
			line_q    <= ~level_q;
			stuffed_q <= 1'b1;
			last_q    <= sts.cnt_zero;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_level  = line_q;
	assign stuffed_bit = stuffed_q;
	assign last_bit    = last_q;

endmodule

`default_nettype wire

FILE: hdl/hdlc_nrzi_transmit_framer.sv
// HDLC NRZI transmit framer: top level joining hnf_ctrl and hnf_dpath.
// Depends on hnf_pkg, hnf_ctrl and hnf_dpath.
//
// Each accepted command produces one line bit per cycle on the output channel, LSB first,
// while out_stall is low: a data byte gives 8 to 10 bits, a flag byte 8, an FCS 16 to 20,
// and a CRC reset none. One command is in flight at a time: a new command is accepted only
// once the previous one has issued its last bit, and every bit passes through the single
// output register, which out_stall holds. last_bit marks the final bit of each command.
`default_nettype none

module hdlc_nrzi_transmit_framer
	import hnf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            line_level,
	output logic            stuffed_bit,
	output logic            last_bit
);

	hnf_cmd_t cmd;
	hnf_sts_t sts;

	hnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	hnf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_level  (line_level),
		.stuffed_bit (stuffed_bit),
		.last_bit    (last_bit)
	);

endmodule

`default_nettype wire

FILE: verif/tb_hdlc_nrzi_transmit_framer.sv
// Self-checking testbench for hdlc_nrzi_transmit_framer: directed command table, then random frames and commands.
// Line bits are checked against hand-worked table rows or an in-bench bit-stuffing, CRC-16 and NRZI encoder.
// Depends on hnf_pkg and the framer RTL.
`default_nettype none

module tb_hdlc_nrzi_transmit_framer;
	import hnf_pkg::*;

	localparam logic [2:0] STUFF_RUN  = 3'd5;
	localparam int         ITEM_COUNT = 280;
	localparam int         IDLE_LIMIT = 2000;
	localparam int         MAX_SHOWN  = 10;
	localparam int         TAIL_WAIT  = 32;
	localparam int         ROW_COUNT  = 25;

	typedef struct packed {
		logic level;
		logic stuffed;
		logic last;
	} line_bit_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  octet;
		logic        typed;
		logic [4:0]  nbits;
		logic [19:0] levels;
		logic [19:0] stuffs;
	} cmd_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] mode;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic       line_level;
	logic       stuffed_bit;
	logic       last_bit;

	line_bit_t   due_bits[$];
	line_bit_t   encoded_bits[$];
	logic [15:0] crc_track;
	logic        level_track;
	logic [2:0]  ones_track;

	int  fail_count;
	int  items_sent;
	int  bits_seen;
	int  rx_hold;
	int  idle_cycles;
	bit  tx_calm;
	bit  rx_calm;

	// Rows 0-4 carry hand-worked line bits from the reset state.
	cmd_row_t cmd_table [ROW_COUNT] = '{
		'{MODE_RESET, 8'h00, 1'b1, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FLAG,  8'hA5, 1'b1, 5'd8,  20'h0007F, 20'h00000},
		'{MODE_FCS,   8'h3C, 1'b1, 5'd16, 20'h05555, 20'h00000},
		'{MODE_DATA,  8'hFF, 1'b1, 5'd9,  20'h001E0, 20'h00020},
		'{MODE_DATA,  8'h00, 1'b1, 5'd8,  20'h000AA, 20'h00000},
		'{MODE_FCS,   8'h00, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FLAG,  8'hFF, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_RESET, 8'h5A, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FLAG,  8'h00, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'h7E, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'hF0, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'h0F, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'hBF, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'h1F, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'hF8, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'h55, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'hAA, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'h01, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_DATA,  8'h80, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FCS,   8'hFF, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FLAG,  8'h80, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FLAG,  8'h01, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_RESET, 8'hFF, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_RESET, 8'h00, 1'b0, 5'd0,  20'h00000, 20'h00000},
		'{MODE_FCS,   8'hC3, 1'b0, 5'd0,  20'h00000, 20'h00000}
	};

	hdlc_nrzi_transmit_framer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_level (line_level),
		.stuffed_bit(stuffed_bit),
		.last_bit   (last_bit)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void push_line_bit(logic stuffed);
		line_bit_t lb;
		lb.level   = level_track;
		lb.stuffed = stuffed;
		lb.last    = 1'b0;
		encoded_bits.push_back(lb);
	endfunction

	function automatic void shift_octet(logic [7:0] octet, logic stuff_on, logic crc_on);
		logic b;
		for (int i = 0; i < 8; i++) begin
			b = octet[i];
			if (crc_on) begin
				if (crc_track[0] ^ b)
					crc_track = (crc_track >> 1) ^ CRC_POLY;
				else
					crc_track = crc_track >> 1;
			end
			if (b) begin
				push_line_bit(1'b0);
				if (ones_track != ONES_MAX)
					ones_track = ones_track + 3'd1;
				if (stuff_on && ones_track == STUFF_RUN) begin
					level_track = ~level_track;
					push_line_bit(1'b1);
					ones_track = '0;
				end
			end else begin
				level_track = ~level_track;
				push_line_bit(1'b0);
				ones_track = '0;
			end
		end
	endfunction

	function automatic void encode_command(logic [1:0] op, logic [7:0] octet);
		logic [15:0] fcs;
		line_bit_t   tail;
		encoded_bits.delete();
		fcs = ~crc_track;
		case (op)
			MODE_DATA: shift_octet(octet, 1'b1, 1'b1);
			MODE_FLAG: shift_octet(FLAG_BYTE, 1'b0, 1'b0);
			MODE_FCS: begin
				shift_octet(fcs[7:0], 1'b1, 1'b0);
				shift_octet(fcs[15:8], 1'b1, 1'b0);
			end
			default: crc_track = CRC_PRESET;
		endcase
		if (encoded_bits.size() > 0) begin
			tail = encoded_bits.pop_back();
			tail.last = 1'b1;
			encoded_bits.push_back(tail);
		end
	endfunction

	function automatic logic [7:0] frame_octet();
		logic [7:0] octet;
		// favor long runs of ones to exercise stuffing
		case ($urandom_range(0, 3))
			0: octet = ~(8'h01 << $urandom_range(0, 7));
			1: octet = 8'hFF >> $urandom_range(0, 7);
			default: octet = 8'($urandom_range(0, 255));
		endcase
		return octet;
	endfunction

	task automatic send_row(cmd_row_t row);
		int        gap;
		line_bit_t lb;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= row.op;
		data_byte <= row.octet;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		items_sent++;
		encode_command(row.op, row.octet);
		if (row.typed) begin
			for (int i = 0; i < row.nbits; i++) begin
				lb.level   = row.levels[i];
				lb.stuffed = row.stuffs[i];
				lb.last    = (i == row.nbits - 1);
				due_bits.push_back(lb);
			end
		end else begin
			foreach (encoded_bits[i]) due_bits.push_back(encoded_bits[i]);
		end
	endtask

	task automatic send_command(logic [1:0] op, logic [7:0] octet);
		cmd_row_t row;
		row       = '0;
		row.op    = op;
		row.octet = octet;
		send_row(row);
	endtask

	task automatic drain_line();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_bits.size() != 0) @(posedge clk);
	endtask

	task automatic check_line_bit();
		line_bit_t want;
		if (due_bits.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_SHOWN)
				$display("unexpected line bit %0d: level %b stuffed %b last %b",
					bits_seen, line_level, stuffed_bit, last_bit);
		end else begin
			want = due_bits.pop_front();
			if (line_level !== want.level || stuffed_bit !== want.stuffed ||
					last_bit !== want.last) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("line bit %0d: exp level %b stuffed %b last %b, got %b %b %b",
						bits_seen, want.level, want.stuffed, want.last,
						line_level, stuffed_bit, last_bit);
			end
		end
		bits_seen++;
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			check_line_bit();
			rx_hold = rx_calm ? 0 : $urandom_range(0, 8);
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		out_stall <= (rx_hold > 0);
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int frames;
		int nbytes;
		in_valid    = 1'b0;
		mode        = MODE_DATA;
		data_byte   = 8'h00;
		out_stall   = 1'b0;
		arst_n      = 1'b0;
		crc_track   = CRC_PRESET;
		level_track = 1'b0;
		ones_track  = '0;
		fail_count  = 0;
		items_sent  = 0;
		bits_seen   = 0;
		rx_hold     = 0;
		idle_cycles = 0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		frames      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < ROW_COUNT; r++) begin
			tx_calm = (r >= 15);
			rx_calm = (r >= 15 && r < 20);
			send_row(cmd_table[r]);
		end
		drain_line();

		while (items_sent < ITEM_COUNT) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 4))
					send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				send_command(MODE_RESET, 8'($urandom_range(0, 255)));
				send_command(MODE_FLAG, 8'($urandom_range(0, 255)));
				nbytes = $urandom_range(1, 6);
				repeat (nbytes) send_command(MODE_DATA, frame_octet());
				send_command(MODE_FCS, 8'($urandom_range(0, 255)));
				send_command(MODE_FLAG, 8'($urandom_range(0, 255)));
			end
			frames++;
			if (frames % 8 == 0)
				drain_line();
		end

		drain_line();
		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
